// File: design/oaht_pkg.sv
// Shared constants, codes and types for the open-addressing hash table.
`default_nettype none

package oaht_pkg;

    // Table geometry; slot indexes wrap with a mask, so the size is a power of two.
    localparam int TABLE_SIZE = 16;
    localparam int IDX_W      = 4;
    localparam int KEY_W      = 34;
    localparam int CNT_W      = 5;
    localparam int STAT_W     = 3;
    localparam int REQ_W      = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STAT_W-1:0] STAT_CLEARED   = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_PROBE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic gen_start;
        logic gen_step;
        logic probe_done;
        logic key_write;
    } ctrl_t;

endpackage

`default_nettype wire

// File: design/oaht_key_store.sv
// Key storage: one write port and one registered read port.
`default_nettype none

module oaht_key_store (
    input  wire logic                       aclk,
    input  wire logic                       we,
    input  wire logic [oaht_pkg::IDX_W-1:0] waddr,
    input  wire logic [oaht_pkg::KEY_W-1:0] wdata,
    input  wire logic [oaht_pkg::IDX_W-1:0] raddr,
    output logic      [oaht_pkg::KEY_W-1:0] rdata
);

    logic [oaht_pkg::KEY_W-1:0] mem [oaht_pkg::TABLE_SIZE];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: design/oaht_probe_gen.sv
// Probe address generator: walks the linear or quadratic sequence from the home slot.
`default_nettype none

module oaht_probe_gen (
    input  wire logic                       aclk,
    input  wire logic                       start,
    input  wire logic                       step,
    input  wire logic                       quad,
    input  wire logic [oaht_pkg::IDX_W-1:0] home,
    output logic      [oaht_pkg::IDX_W-1:0] slot
);

    logic [oaht_pkg::IDX_W-1:0] home_reg;
    logic [oaht_pkg::IDX_W-1:0] off_reg;
    logic [oaht_pkg::IDX_W-1:0] j_reg;
    logic [oaht_pkg::IDX_W-1:0] incr;

    // The square grows by 2j+1 from one probe to the next, taken modulo the table size.
    assign incr = quad ? {j_reg[oaht_pkg::IDX_W-2:0], 1'b1} : oaht_pkg::IDX_W'(1);
    assign slot = home_reg + off_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            home_reg <= home;
            off_reg  <= '0;
            j_reg    <= '0;
        end else if (step) begin
            off_reg <= off_reg + incr;
            j_reg   <= j_reg + oaht_pkg::IDX_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: design/open_addressing_hash_table.sv
// Top level of the open-addressing hash table with linear or quadratic probing.
// An insert or lookup that examines k slots (1 to 16) holds the block from the accepting
// cycle through a fetch of the first stored key, one probe per cycle, and the hand-off of
// the result to the output register, which waits while the output is stalled. A clear
// goes straight from acceptance to that hand-off. Requests are taken one at a time, as set by the probe sequencer.
// Reset empties every slot and selects linear probing; stored keys are not cleared.
`default_nettype none

module open_addressing_hash_table (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // Configuration: probe mode, 0 linear, 1 quadratic.
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    // Request channel.
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [oaht_pkg::REQ_W-1:0]  s_req_type,
    input  wire logic [oaht_pkg::KEY_W-1:0]  s_key,
    // Result channel.
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic      [oaht_pkg::STAT_W-1:0] m_status,
    output logic      [oaht_pkg::IDX_W-1:0]  m_slot,
    output logic      [oaht_pkg::CNT_W-1:0]  m_probe_count
);

    oaht_pkg::state_t state_reg;
    oaht_pkg::state_t state_next;
    oaht_pkg::ctrl_t  ctrl;

    logic                          probe_mode_reg;
    logic [oaht_pkg::TABLE_SIZE-1:0] valid_reg;
    logic [oaht_pkg::REQ_W-1:0]    req_reg;
    logic [oaht_pkg::KEY_W-1:0]    key_reg;
    logic [oaht_pkg::IDX_W-1:0]    cmp_slot_reg;
    logic [oaht_pkg::CNT_W-1:0]    pcount_reg;

    logic [oaht_pkg::STAT_W-1:0]   res_status_reg;
    logic [oaht_pkg::IDX_W-1:0]    res_slot_reg;
    logic [oaht_pkg::CNT_W-1:0]    res_count_reg;

    logic                          m_valid_reg;
    logic [oaht_pkg::STAT_W-1:0]   m_status_reg;
    logic [oaht_pkg::IDX_W-1:0]    m_slot_reg;
    logic [oaht_pkg::CNT_W-1:0]    m_count_reg;

    logic [oaht_pkg::IDX_W-1:0]    gen_slot;
    logic [oaht_pkg::KEY_W-1:0]    rd_key;

    logic                          s_fire;
    logic                          probe_valid;
    logic                          key_hit;
    logic                          last_probe;
    logic                          out_free;
    logic [oaht_pkg::CNT_W-1:0]    count_now;
    logic [oaht_pkg::STAT_W-1:0]   done_status;
    logic [oaht_pkg::IDX_W-1:0]    done_slot;

    // The generator yields the slot of the next probe; its stored key is read in the cycle
    // before, so a probe result is judged every cycle in the probe state.
    oaht_probe_gen u_gen (
        .aclk  (aclk),
        .start (ctrl.gen_start),
        .step  (ctrl.gen_step),
        .quad  (probe_mode_reg),
        .home  (s_key[oaht_pkg::IDX_W-1:0]),
        .slot  (gen_slot)
    );

    oaht_key_store u_store (
        .aclk  (aclk),
        .we    (ctrl.key_write),
        .waddr (cmp_slot_reg),
        .wdata (key_reg),
        .raddr (gen_slot),
        .rdata (rd_key)
    );

    assign s_fire      = s_valid && ctrl.s_ready;
    assign probe_valid = valid_reg[cmp_slot_reg];
    assign key_hit     = (rd_key == key_reg);
    assign last_probe  = (pcount_reg == oaht_pkg::CNT_W'(oaht_pkg::TABLE_SIZE - 1));
    assign count_now   = pcount_reg + oaht_pkg::CNT_W'(1);
    assign out_free    = !m_valid_reg || m_ready;

    // Outcome of the slot examined in this cycle.
    always_comb begin
        done_status = oaht_pkg::STAT_NOT_FOUND;
        done_slot   = '0;
        if (req_reg == oaht_pkg::REQ_INSERT) begin
            if (!probe_valid) begin
                done_status = oaht_pkg::STAT_INSERTED;
                done_slot   = cmp_slot_reg;
            end else begin
                done_status = oaht_pkg::STAT_FULL;
            end
        end else if (probe_valid && key_hit) begin
            done_status = oaht_pkg::STAT_FOUND;
            done_slot   = cmp_slot_reg;
        end
    end

    // Sequencer outputs.
    always_comb begin
        ctrl = '0;
        case (state_reg)
            oaht_pkg::ST_IDLE: begin
                ctrl.s_ready   = 1'b1;
                ctrl.gen_start = 1'b1;
            end
            oaht_pkg::ST_FETCH: begin
                ctrl.gen_step = 1'b1;
            end
            oaht_pkg::ST_PROBE: begin
                ctrl.gen_step = 1'b1;
                if (req_reg == oaht_pkg::REQ_INSERT) begin
                    ctrl.probe_done = !probe_valid || last_probe;
                    ctrl.key_write  = !probe_valid;
                end else begin
                    ctrl.probe_done = !probe_valid || key_hit || last_probe;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            oaht_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_req_type == oaht_pkg::REQ_CLEAR) begin
                        state_next = oaht_pkg::ST_DONE;
                    end else if (s_req_type == oaht_pkg::REQ_INSERT ||
                                 s_req_type == oaht_pkg::REQ_LOOKUP) begin
                        state_next = oaht_pkg::ST_FETCH;
                    end
                end
            end
            oaht_pkg::ST_FETCH: begin
                state_next = oaht_pkg::ST_PROBE;
            end
            oaht_pkg::ST_PROBE: begin
                if (ctrl.probe_done) begin
                    state_next = oaht_pkg::ST_DONE;
                end
            end
            oaht_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = oaht_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = oaht_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state: sequencer, probe mode, slot occupancy marks and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= oaht_pkg::ST_IDLE;
            probe_mode_reg <= 1'b0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                probe_mode_reg <= cfg_wdata;
            end
            if (s_fire && s_req_type == oaht_pkg::REQ_CLEAR) begin
                valid_reg <= '0;
            end else if (ctrl.key_write) begin
                valid_reg[cmp_slot_reg] <= 1'b1;
            end
            if (state_reg == oaht_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg        <= s_req_type;
            key_reg        <= s_key;
            pcount_reg     <= '0;
            res_status_reg <= oaht_pkg::STAT_CLEARED;
            res_slot_reg   <= '0;
            res_count_reg  <= '0;
        end
        if (state_reg == oaht_pkg::ST_FETCH || state_reg == oaht_pkg::ST_PROBE) begin
            cmp_slot_reg <= gen_slot;
        end
        if (state_reg == oaht_pkg::ST_PROBE) begin
            pcount_reg <= count_now;
            if (ctrl.probe_done) begin
                res_status_reg <= done_status;
                res_slot_reg   <= done_slot;
                res_count_reg  <= count_now;
            end
        end
        if (state_reg == oaht_pkg::ST_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_slot_reg   <= res_slot_reg;
            m_count_reg  <= res_count_reg;
        end
    end

    assign s_ready       = ctrl.s_ready;
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_slot        = m_slot_reg;
    assign m_probe_count = m_count_reg;

endmodule

`default_nettype wire
